### rtl/core/tr_mac_pkg.sv
package tr_mac_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 16;

  localparam int unsigned ROUND_W = 16;
  localparam int unsigned ADDR_W  = 8;
  localparam int unsigned PRIO_W  = 3;
  localparam int unsigned TYPE_W  = 2;

  // one table entry: {prio, dst, round}
  localparam int unsigned ENTRY_W = ROUND_W + ADDR_W + PRIO_W;

  localparam logic [TYPE_W-1:0] FRAME_TOKEN = 2'd0;
  localparam logic [TYPE_W-1:0] FRAME_DATA  = 2'd1;
  localparam logic [TYPE_W-1:0] FRAME_ACK   = 2'd2;
  localparam logic [TYPE_W-1:0] FRAME_RSVD  = 2'd3;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  typedef struct packed {
    logic capture;
    logic scan_en;
    logic shift_init;
    logic shift_en;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_add;
    logic scan_done;
    logic send;
    logic shift_done;
    logic out_free;
  } ctl_sts_t;

endpackage

### rtl/core/tr_mac_ram.sv
module tr_mac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/tr_mac_ctrl.sv
module tr_mac_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tr_mac_pkg::ctl_sts_t sts_i,
  output tr_mac_pkg::ctl_cmd_t cmd_o
);
  import tr_mac_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.is_add || sts_i.scan_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd_o.shift_init = 1'b1;
        state_d = sts_i.send ? ST_SHIFT : ST_RESULT;
      end
      ST_SHIFT: begin
        cmd_o.shift_en = 1'b1;
        if (sts_i.shift_done) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/core/tr_mac_dp.sv
module tr_mac_dp #(
  parameter int unsigned TABLE_DEPTH = tr_mac_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tr_mac_pkg::ctl_cmd_t cmd_i,
  output tr_mac_pkg::ctl_sts_t sts_o,
  input  logic                 cfg_valid_i,
  input  logic [7:0]           cfg_data_i,
  input  logic [2:0]           s_axis_tuser,
  input  logic [47:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [1:0]           m_axis_tuser,
  output logic [23:0]          m_axis_tdata
);
  import tr_mac_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // captured request
  logic                it_cmd_q;
  logic [ROUND_W-1:0]  it_round_q;
  logic [ADDR_W-1:0]   it_rdst_q;
  logic [PRIO_W-1:0]   it_rprio_q;
  logic [TYPE_W-1:0]   it_ftype_q;
  logic [PRIO_W-1:0]   it_fprio_q;
  logic [ADDR_W-1:0]   it_fsrc_q;
  logic [ADDR_W-1:0]   it_fdst_q;

  logic [ADDR_W-1:0]   station_id_q;
  logic [CW-1:0]       cnt_q;
  logic [ROUND_W-1:0]  frame_count_q;
  logic                saved_valid_q;
  logic [PRIO_W-1:0]   saved_prio_q;

  // scan pipeline and best candidate
  logic [CW-1:0]       idx_q;
  logic                pv_q;
  logic [AW-1:0]       pidx_q;
  logic                found_q;
  logic [AW-1:0]       best_idx_q;
  logic [ROUND_W-1:0]  best_round_q;
  logic [ADDR_W-1:0]   best_dst_q;
  logic [PRIO_W-1:0]   best_prio_q;

  // compaction pipeline
  logic [CW-1:0]       sidx_q;
  logic                wpend_q;
  logic [AW-1:0]       waddr_q;

  // result register
  logic                out_valid_q;
  logic [TYPE_W-1:0]   out_type_q;
  logic [PRIO_W-1:0]   out_prio_q;
  logic [ADDR_W-1:0]   out_src_q;
  logic [ADDR_W-1:0]   out_dst_q;
  logic                out_sent_q;
  logic                out_done_q;
  logic                out_acc_q;

  logic                scan_issue;
  logic [CW-1:0]       sidx_nxt;
  logic                shift_issue;
  logic                full;
  logic [AW-1:0]       raddr;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [ROUND_W-1:0]  rd_round;
  logic [ADDR_W-1:0]   rd_dst;
  logic [PRIO_W-1:0]   rd_prio;
  logic                better;

  logic [TYPE_W-1:0]   ftype_eff;
  logic                send;
  logic                reserve;
  logic [TYPE_W-1:0]   res_type;
  logic [PRIO_W-1:0]   res_prio;
  logic [ADDR_W-1:0]   res_src;
  logic [ADDR_W-1:0]   res_dst;
  logic                res_done;
  logic                saved_valid_d;
  logic [PRIO_W-1:0]   saved_prio_d;

  assign full        = (cnt_q == CW'(TABLE_DEPTH));
  assign scan_issue  = (idx_q < cnt_q);
  assign sidx_nxt    = sidx_q + CW'(1);
  assign shift_issue = (sidx_nxt < cnt_q);
  assign raddr       = cmd_i.shift_en ? sidx_nxt[AW-1:0] : idx_q[AW-1:0];

  assign rd_round = ram_rdata[ROUND_W-1:0];
  assign rd_dst   = ram_rdata[ROUND_W +: ADDR_W];
  assign rd_prio  = ram_rdata[ROUND_W+ADDR_W +: PRIO_W];
  // strict less keeps the earliest inserted among equal rounds
  assign better   = (rd_round <= frame_count_q) && (!found_q || (rd_round < best_round_q));

  always_comb begin
    if (wpend_q) begin
      ram_we    = 1'b1;
      ram_waddr = waddr_q;
      ram_wdata = ram_rdata;
    end else begin
      ram_we    = cmd_i.commit && (it_cmd_q == CMD_ADD) && !full;
      ram_waddr = cnt_q[AW-1:0];
      ram_wdata = {it_rprio_q, it_rdst_q, it_round_q};
    end
  end

  tr_mac_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // frame handling
  always_comb begin
    ftype_eff     = (it_ftype_q == FRAME_RSVD) ? FRAME_ACK : it_ftype_q;
    send          = 1'b0;
    reserve       = 1'b0;
    res_type      = ftype_eff;
    res_prio      = it_fprio_q;
    res_src       = it_fsrc_q;
    res_dst       = it_fdst_q;
    res_done      = 1'b0;
    saved_valid_d = saved_valid_q;
    saved_prio_d  = saved_prio_q;
    if (ftype_eff == FRAME_TOKEN) begin
      if (found_q && (best_prio_q >= it_fprio_q)) begin
        send     = 1'b1;
        res_type = FRAME_DATA;
        res_src  = station_id_q;
        res_dst  = best_dst_q;
        if (saved_valid_q) begin
          res_prio      = saved_prio_q;
          saved_valid_d = 1'b0;
        end
      end
    end else begin
      reserve = found_q && (best_prio_q > it_fprio_q);
      if (it_fdst_q == station_id_q) begin
        res_dst = it_fsrc_q;
        res_src = station_id_q;
        if (ftype_eff == FRAME_DATA) begin
          res_type = FRAME_ACK;
        end else begin
          res_type = FRAME_TOKEN;
          res_done = 1'b1;
          reserve  = 1'b0;
        end
      end
      if (reserve) begin
        saved_prio_d  = it_fprio_q;
        saved_valid_d = 1'b1;
        res_prio      = best_prio_q;
      end
    end
  end

  assign sts_o.is_add     = (it_cmd_q == CMD_ADD);
  assign sts_o.scan_done  = !scan_issue && !pv_q;
  assign sts_o.send       = (it_cmd_q == CMD_FRAME) && send;
  assign sts_o.shift_done = !shift_issue && !wpend_q;
  assign sts_o.out_free   = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      it_cmd_q   <= s_axis_tuser[0];
      it_ftype_q <= s_axis_tuser[2:1];
      it_round_q <= s_axis_tdata[15:0];
      it_rdst_q  <= s_axis_tdata[23:16];
      it_rprio_q <= s_axis_tdata[26:24];
      it_fprio_q <= s_axis_tdata[29:27];
      it_fsrc_q  <= s_axis_tdata[37:30];
      it_fdst_q  <= s_axis_tdata[45:38];
    end
    if (cmd_i.scan_en) begin
      pidx_q <= idx_q[AW-1:0];
    end
    if (pv_q && better) begin
      best_idx_q   <= pidx_q;
      best_round_q <= rd_round;
      best_dst_q   <= rd_dst;
      best_prio_q  <= rd_prio;
    end
    if (cmd_i.shift_en) begin
      waddr_q <= sidx_q[AW-1:0];
    end
    if (cmd_i.commit) begin
      out_type_q <= (it_cmd_q == CMD_ADD) ? FRAME_TOKEN : res_type;
      out_prio_q <= (it_cmd_q == CMD_ADD) ? '0 : res_prio;
      out_src_q  <= (it_cmd_q == CMD_ADD) ? '0 : res_src;
      out_dst_q  <= (it_cmd_q == CMD_ADD) ? '0 : res_dst;
      out_sent_q <= sts_o.send;
      out_done_q <= (it_cmd_q == CMD_FRAME) && res_done;
      out_acc_q  <= (it_cmd_q == CMD_ADD) && !full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_id_q  <= '0;
      cnt_q         <= '0;
      frame_count_q <= '0;
      saved_valid_q <= 1'b0;
      saved_prio_q  <= '0;
      idx_q         <= '0;
      pv_q          <= 1'b0;
      found_q       <= 1'b0;
      sidx_q        <= '0;
      wpend_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        station_id_q <= cfg_data_i;
      end
      if (cmd_i.capture) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_en && scan_issue) begin
        idx_q <= idx_q + CW'(1);
      end
      pv_q <= cmd_i.scan_en && scan_issue;
      if (pv_q && better) begin
        found_q <= 1'b1;
      end
      if (cmd_i.shift_init) begin
        sidx_q <= CW'(best_idx_q);
      end else if (cmd_i.shift_en && shift_issue) begin
        sidx_q <= sidx_nxt;
      end
      wpend_q <= cmd_i.shift_en && shift_issue;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (it_cmd_q == CMD_ADD) begin
          if (!full) begin
            cnt_q <= cnt_q + CW'(1);
          end
        end else begin
          frame_count_q <= frame_count_q + ROUND_W'(1);
          saved_valid_q <= saved_valid_d;
          saved_prio_q  <= saved_prio_d;
          if (send) begin
            cnt_q <= cnt_q - CW'(1);
          end
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_type_q;
  assign m_axis_tdata  = {2'b00, out_acc_q, out_done_q, out_sent_q,
                          out_dst_q, out_src_q, out_prio_q};

endmodule

### rtl/core/token_ring_station_priority_mac.sv
// Priority-reservation MAC of one token ring station. A request on the slave
// stream either queues a pending send (tuser bit 0 low) or hands over one frame
// from upstream (tuser bit 0 high); each request gives exactly one result on the
// master stream, which holds in its output register while the next request is
// taken. Requests are handled one at a time. Pending sends live in a memory kept
// in arrival order, and every table access goes through its single read port:
// queueing skips the scan, a frame scans every pending entry in order, and a
// frame that launches entry k (from 0) then moves each later entry down one
// place to close the gap in the table. A result not yet taken on the master
// stream holds the next request in its last cycle until the output register
// frees. The station address is written on the cfg channel; the user must do so
// only while the block is idle, which the block itself does not enforce, and it
// is accepted in any cycle.
module token_ring_station_priority_mac #(
  parameter int unsigned TABLE_DEPTH = tr_mac_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,     // station_id
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,   // cmd, frame_type[1:0]
  // req_round[15:0], req_dst[7:0], req_prio[2:0], frame_prio[2:0],
  // frame_src[7:0], frame_dst[7:0], zero pad[1:0]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [1:0]  m_axis_tuser,   // out_type[1:0]
  // out_prio[2:0], out_src[7:0], out_dst[7:0], sent_request, exchange_done,
  // accepted, zero pad[1:0]
  output logic [23:0] m_axis_tdata
);
  import tr_mac_pkg::*;

  ctl_cmd_t ctl_cmd;
  ctl_sts_t ctl_sts;

  assign cfg_ready_o = 1'b1;

  tr_mac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (ctl_sts),
    .cmd_o      (ctl_cmd)
  );

  tr_mac_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctl_cmd),
    .sts_o         (ctl_sts),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in work");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(ctl_cmd.commit))
    else $error("result shown without a commit");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($countones(m_axis_tdata[21:19]) <= 1))
    else $error("more than one outcome flag set");

  a_add_result_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[21]) |-> (m_axis_tuser == FRAME_TOKEN))
    else $error("queued send reported with a frame");
`endif

endmodule

### bench/station_frame_checker.sv
`timescale 1ns / 1ps

module station_frame_checker
  import tr_mac_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [2:0]  req_user_i,
  input  logic [47:0] req_data_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [1:0]  res_user_i,
  input  logic [23:0] res_data_i,
  output int          mismatches_o,
  output int          in_flight_o,
  output int          launches_o,
  output int          exchanges_o,
  output int          refusals_o
);

  typedef struct packed {
    logic [ROUND_W-1:0] round;
    logic [ADDR_W-1:0]  dst;
    logic [PRIO_W-1:0]  prio;
  } pending_send_t;

  typedef struct packed {
    logic [TYPE_W-1:0] kind;
    logic [PRIO_W-1:0] prio;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic              launched;
    logic              exch_done;
    logic              stored;
  } station_frame_t;

  // own copy of the station
  logic [ADDR_W-1:0]  station;
  pending_send_t      pending_sends[$];
  logic [ROUND_W-1:0] frame_cnt;
  logic               rsv_valid;
  logic [PRIO_W-1:0]  rsv_prio;

  station_frame_t     awaited_frames[$];
  station_frame_t     got;
  station_frame_t     want;

  function automatic station_frame_t next_station_frame(
    input logic              cmd,
    input logic [TYPE_W-1:0] ftype,
    input logic [ROUND_W-1:0] rround,
    input logic [ADDR_W-1:0] rdst,
    input logic [PRIO_W-1:0] rprio,
    input logic [PRIO_W-1:0] fprio,
    input logic [ADDR_W-1:0] fsrc,
    input logic [ADDR_W-1:0] fdst
  );
    station_frame_t r;
    pending_send_t  ent;
    int             pick;
    logic           reserve;
    r = '0;
    if (cmd == CMD_ADD) begin
      if (pending_sends.size() < TABLE_DEPTH) begin
        ent.round = rround;
        ent.dst   = rdst;
        ent.prio  = rprio;
        pending_sends.insert(pending_sends.size(), ent);
        r.stored = 1'b1;
      end else begin
        refusals_o++;
      end
      return r;
    end
    // least round that is due; ties go to the oldest entry
    pick = -1;
    foreach (pending_sends[i]) begin
      if (pending_sends[i].round <= frame_cnt &&
          (pick < 0 || pending_sends[i].round < pending_sends[pick].round))
        pick = i;
    end
    if (ftype == FRAME_RSVD) ftype = FRAME_ACK;
    r.kind = ftype;
    r.prio = fprio;
    r.src  = fsrc;
    r.dst  = fdst;
    if (ftype == FRAME_TOKEN) begin
      if (pick >= 0 && pending_sends[pick].prio >= fprio) begin
        r.kind = FRAME_DATA;
        r.src  = station;
        r.dst  = pending_sends[pick].dst;
        if (rsv_valid) begin
          r.prio    = rsv_prio;
          rsv_valid = 1'b0;
        end
        r.launched = 1'b1;
        pending_sends.delete(pick);
        launches_o++;
      end
    end else begin
      reserve = (pick >= 0 && pending_sends[pick].prio > fprio);
      if (fdst == station) begin
        r.dst = fsrc;
        r.src = station;
        if (ftype == FRAME_DATA) begin
          r.kind = FRAME_ACK;
        end else begin
          r.kind      = FRAME_TOKEN;
          r.exch_done = 1'b1;
          reserve     = 1'b0;
          exchanges_o++;
        end
      end
      if (reserve) begin
        rsv_prio  = fprio;
        rsv_valid = 1'b1;
        r.prio    = pending_sends[pick].prio;
      end
    end
    frame_cnt = frame_cnt + ROUND_W'(1);
    return r;
  endfunction

  task automatic check_field(input string what, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      mismatches_o++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station   = '0;
      frame_cnt = '0;
      rsv_valid = 1'b0;
      rsv_prio  = '0;
      pending_sends.delete();
      awaited_frames.delete();
      mismatches_o = 0;
      in_flight_o  = 0;
      launches_o   = 0;
      exchanges_o  = 0;
      refusals_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) station = cfg_data_i;
      if (res_valid_i && res_ready_i) begin
        got.kind      = res_user_i;
        got.prio      = res_data_i[2:0];
        got.src       = res_data_i[10:3];
        got.dst       = res_data_i[18:11];
        got.launched  = res_data_i[19];
        got.exch_done = res_data_i[20];
        got.stored    = res_data_i[21];
        if (awaited_frames.size() == 0) begin
          mismatches_o++;
          $display("%0t: result with no request outstanding, type 0x%0h data 0x%0h",
                   $time, res_user_i, res_data_i);
        end else begin
          want = awaited_frames.pop_front();
          check_field("out_type", 8'(want.kind), 8'(got.kind));
          check_field("out_prio", 8'(want.prio), 8'(got.prio));
          check_field("out_src", want.src, got.src);
          check_field("out_dst", want.dst, got.dst);
          check_field("sent_request", 8'(want.launched), 8'(got.launched));
          check_field("exchange_done", 8'(want.exch_done), 8'(got.exch_done));
          check_field("accepted", 8'(want.stored), 8'(got.stored));
        end
      end
      if (req_valid_i && req_ready_i)
        awaited_frames.insert(awaited_frames.size(),
                              next_station_frame(req_user_i[0], req_user_i[2:1],
                                                 req_data_i[15:0], req_data_i[23:16],
                                                 req_data_i[26:24], req_data_i[29:27],
                                                 req_data_i[37:30], req_data_i[45:38]));
      in_flight_o = awaited_frames.size();
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tr_mac_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned BATCH_ITEMS   = 254;
  localparam int unsigned BATCHES       = 6;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser  = '0;
  logic [47:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [1:0]  m_axis_tuser;
  logic [23:0] m_axis_tdata;

  int          mismatches;
  int          in_flight;
  int          launches;
  int          exchanges;
  int          refusals;

  logic [7:0]  station_id = '0;
  bit          quiet      = 1'b0;
  int unsigned frames_sent;
  int unsigned adds_sent;
  int unsigned cfg_writes;
  int unsigned idle_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  token_ring_station_priority_mac dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  station_frame_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_user_i   (s_axis_tuser),
    .req_data_i   (s_axis_tdata),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_user_i   (m_axis_tuser),
    .res_data_i   (m_axis_tdata),
    .mismatches_o (mismatches),
    .in_flight_o  (in_flight),
    .launches_o   (launches),
    .exchanges_o  (exchanges),
    .refusals_o   (refusals)
  );

  // called at a falling edge, returns at the falling edge after the request is taken
  task automatic push_item(input logic cmd, input logic [1:0] ftype,
                           input logic [15:0] rround, input logic [7:0] rdst,
                           input logic [2:0] rprio, input logic [2:0] fprio,
                           input logic [7:0] fsrc, input logic [7:0] fdst);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {ftype, cmd};
    s_axis_tdata  <= {2'b00, fdst, fsrc, fprio, rprio, rdst, rround};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    if (cmd == CMD_FRAME) frames_sent++;
    else adds_sent++;
  endtask

  task automatic push_random(input bit add_only);
    logic [15:0] rround;
    logic [1:0]  ftype;
    logic [2:0]  fprio;
    logic [7:0]  fdst;
    int unsigned roll;
    int unsigned base;
    base = frames_sent;
    // rounds mostly near the station's frame count so requests become due
    roll = $urandom_range(0, 9);
    if (roll < 4) rround = 16'(base + $urandom_range(0, 12));
    else if (roll < 8) rround = 16'((base > 20) ? base - $urandom_range(0, 20)
                                                : $urandom_range(0, base));
    else if (roll == 8) rround = '0;
    else rround = 16'(base + $urandom_range(13, 80));
    roll = $urandom_range(0, 19);
    ftype = (roll < 9) ? FRAME_TOKEN : (roll < 14) ? FRAME_DATA :
            (roll < 18) ? FRAME_ACK : FRAME_RSVD;
    fprio = 3'($urandom_range(0, 7));
    if (ftype == FRAME_TOKEN && $urandom_range(0, 4) < 3) fprio = '0;
    fdst = ($urandom_range(0, 4) < 2) ? station_id : 8'($urandom_range(0, 255));
    push_item((add_only || $urandom_range(0, 3) == 0) ? CMD_ADD : CMD_FRAME, ftype,
              rround, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), fprio,
              8'($urandom_range(0, 255)), fdst);
  endtask

  task automatic set_station(input logic [7:0] id);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= id;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    station_id = id;
    cfg_writes++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (in_flight != 0) @(negedge clk_i);
    // quiet gap before the station address may change
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // result side
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] corner [3];
    int unsigned burst;
    corner = '{8'h00, 8'h7F, 8'hFF};
    frames_sent = 0;
    adds_sent   = 0;
    cfg_writes  = 0;
    burst       = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_station(8'hFF);
    // token with nothing queued passes through
    push_item(CMD_FRAME, FRAME_TOKEN, 16'h0000, 8'h00, 3'd0, 3'd7, 8'hFF, 8'h00);
    push_item(CMD_ADD, FRAME_TOKEN, 16'h0000, 8'hFF, 3'd7, 3'd0, 8'h00, 8'h00);
    // never due during this run
    push_item(CMD_ADD, FRAME_TOKEN, 16'hFFFF, 8'h00, 3'd0, 3'd0, 8'h00, 8'h00);
    // passing data gets raised, then a passing ack overwrites the reservation
    push_item(CMD_FRAME, FRAME_DATA, 16'h0000, 8'h00, 3'd0, 3'd0, 8'h12, 8'h34);
    push_item(CMD_FRAME, FRAME_ACK, 16'h0000, 8'h00, 3'd0, 3'd3, 8'h56, 8'h78);
    // launch picks up the saved priority
    push_item(CMD_FRAME, FRAME_TOKEN, 16'h0000, 8'h00, 3'd0, 3'd7, 8'h9A, 8'hBC);
    push_item(CMD_FRAME, FRAME_TOKEN, 16'h0000, 8'h00, 3'd0, 3'd0, 8'h01, 8'h02);
    // equal rounds: the older, lower priority one is the candidate
    push_item(CMD_ADD, FRAME_TOKEN, 16'd5, 8'h11, 3'd2, 3'd0, 8'h00, 8'h00);
    push_item(CMD_ADD, FRAME_TOKEN, 16'd5, 8'h22, 3'd5, 3'd0, 8'h00, 8'h00);
    push_item(CMD_FRAME, FRAME_TOKEN, 16'h0000, 8'h00, 3'd0, 3'd3, 8'h03, 8'h04);
    // data for us turns into an ack and still reserves
    push_item(CMD_FRAME, FRAME_DATA, 16'h0000, 8'h00, 3'd0, 3'd1, 8'h40, 8'hFF);
    // our ack returns, and the reserved kind counts as an ack
    push_item(CMD_FRAME, FRAME_ACK, 16'h0000, 8'h00, 3'd0, 3'd0, 8'h41, 8'hFF);
    push_item(CMD_FRAME, FRAME_RSVD, 16'h0000, 8'h00, 3'd0, 3'd6, 8'h42, 8'hFF);
    push_item(CMD_FRAME, FRAME_TOKEN, 16'h0000, 8'h00, 3'd0, 3'd2, 8'h05, 8'h06);
    // fill the table past its end
    repeat (15)
      push_item(CMD_ADD, FRAME_TOKEN, 16'($urandom_range(0, 20)), 8'($urandom_range(0, 255)),
                3'($urandom_range(0, 7)), 3'd0, 8'h00, 8'h00);
    drain();

    for (int b = 0; b < BATCHES; b++) begin
      set_station((b % 2 == 1) ? 8'($urandom_range(0, 255)) : corner[b / 2]);
      for (int j = 0; j < BATCH_ITEMS; j++) begin
        if (j % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (burst == 0 && $urandom_range(0, 49) == 0) burst = 12;
        push_random(burst > 0);
        if (burst > 0) burst--;
      end
      drain();
    end

    $display("ran %0d requests (%0d queued sends, %0d frames) under %0d station addresses",
             adds_sent + frames_sent, adds_sent, frames_sent, cfg_writes);
    $display("saw %0d launches, %0d closed exchanges, %0d sends refused on a full table",
             launches, exchanges, refusals);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/tr_mac_pkg.sv
rtl/core/tr_mac_ram.sv
rtl/core/tr_mac_ctrl.sv
rtl/core/tr_mac_dp.sv
rtl/core/token_ring_station_priority_mac.sv
bench/station_frame_checker.sv
bench/tb_top.sv
